/* src/mkse_pkg.sv */
`timescale 1ns / 1ps

package mkse_pkg;

    // Field widths of the channels and the configuration register.
    localparam int CHAR_W  = 8;
    localparam int DOT_W   = 12;
    localparam int DUR_W   = 15;
    localparam int UNITS_W = 3;
    localparam int LEN_W   = 3;
    localparam int SYM_MAX = 6;

    // Range of character codes covered by the Morse table.
    localparam logic [CHAR_W-1:0] CODE_FIRST = 8'd32;
    localparam logic [CHAR_W-1:0] CODE_LAST  = 8'd90;

    // Reset value of the dot length register.
    localparam logic [DOT_W-1:0] DOT_LEN_RESET = 12'd75;

    // Segment lengths in dot units.
    localparam logic [UNITS_W-1:0] UNITS_DOT  = 3'd1;
    localparam logic [UNITS_W-1:0] UNITS_DASH = 3'd3;
    localparam logic [UNITS_W-1:0] UNITS_WORD = 3'd6;
    localparam logic [UNITS_W-1:0] UNITS_SEP  = 3'd1;
    localparam logic [UNITS_W-1:0] UNITS_GAP  = 3'd2;

    // Classified character: symbol count, dash mask (bit j is symbol j, one
    // means dash), word space flag and the out-of-range flag.
    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [SYM_MAX-1:0] dash;
        logic               space;
        logic               unsup;
    } t_desc;

    // Fill state of the queue between the front and the back.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Morse table for codes within range. Characters without a code have
    // zero symbols and send only the closing gap.
    function automatic t_desc mkse_lookup(input logic [CHAR_W-1:0] code);
        t_desc d;
        d = '{len: 3'd0, dash: 6'b000000, space: 1'b0, unsup: 1'b0};
        case (code)
            8'd32: begin d.len = 3'd1; d.space = 1'b1; end
            8'd39: begin d.len = 3'd6; d.dash = 6'b011110; end
            8'd44: begin d.len = 3'd6; d.dash = 6'b110011; end
            8'd46: begin d.len = 3'd6; d.dash = 6'b101010; end
            8'd47: begin d.len = 3'd5; d.dash = 6'b001001; end
            8'd48: begin d.len = 3'd5; d.dash = 6'b011111; end
            8'd49: begin d.len = 3'd5; d.dash = 6'b011110; end
            8'd50: begin d.len = 3'd5; d.dash = 6'b011100; end
            8'd51: begin d.len = 3'd5; d.dash = 6'b011000; end
            8'd52: begin d.len = 3'd5; d.dash = 6'b010000; end
            8'd53: begin d.len = 3'd5; d.dash = 6'b000000; end
            8'd54: begin d.len = 3'd5; d.dash = 6'b000001; end
            8'd55: begin d.len = 3'd5; d.dash = 6'b000011; end
            8'd56: begin d.len = 3'd5; d.dash = 6'b000111; end
            8'd57: begin d.len = 3'd5; d.dash = 6'b001111; end
            8'd63: begin d.len = 3'd6; d.dash = 6'b001100; end
            8'd65: begin d.len = 3'd2; d.dash = 6'b000010; end
            8'd66: begin d.len = 3'd4; d.dash = 6'b000001; end
            8'd67: begin d.len = 3'd4; d.dash = 6'b000101; end
            8'd68: begin d.len = 3'd3; d.dash = 6'b000001; end
            8'd69: begin d.len = 3'd1; d.dash = 6'b000000; end
            8'd70: begin d.len = 3'd4; d.dash = 6'b000100; end
            8'd71: begin d.len = 3'd3; d.dash = 6'b000011; end
            8'd72: begin d.len = 3'd4; d.dash = 6'b000000; end
            8'd73: begin d.len = 3'd2; d.dash = 6'b000000; end
            8'd74: begin d.len = 3'd4; d.dash = 6'b001110; end
            8'd75: begin d.len = 3'd3; d.dash = 6'b000101; end
            8'd76: begin d.len = 3'd4; d.dash = 6'b000010; end
            8'd77: begin d.len = 3'd2; d.dash = 6'b000011; end
            8'd78: begin d.len = 3'd2; d.dash = 6'b000001; end
            8'd79: begin d.len = 3'd3; d.dash = 6'b000111; end
            8'd80: begin d.len = 3'd4; d.dash = 6'b000110; end
            8'd81: begin d.len = 3'd4; d.dash = 6'b001011; end
            8'd82: begin d.len = 3'd3; d.dash = 6'b000010; end
            8'd83: begin d.len = 3'd3; d.dash = 6'b000000; end
            8'd84: begin d.len = 3'd1; d.dash = 6'b000001; end
            8'd85: begin d.len = 3'd3; d.dash = 6'b000100; end
            8'd86: begin d.len = 3'd4; d.dash = 6'b001000; end
            8'd87: begin d.len = 3'd3; d.dash = 6'b000110; end
            8'd88: begin d.len = 3'd4; d.dash = 6'b001001; end
            8'd89: begin d.len = 3'd4; d.dash = 6'b001101; end
            8'd90: begin d.len = 3'd4; d.dash = 6'b000011; end
            default: begin d.len = 3'd0; end
        endcase
        return d;
    endfunction

endpackage

/* src/mkse_char_if.sv */
`timescale 1ns / 1ps

interface mkse_char_if;
    import mkse_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

/* src/mkse_seg_if.sv */
`timescale 1ns / 1ps

interface mkse_seg_if;
    import mkse_pkg::*;

    logic             valid;
    logic             ready;
    logic             key_on;
    logic [DUR_W-1:0] duration;
    logic             unsupported;
    logic             last;

    modport source (output valid, output key_on, output duration, output unsupported,
                    output last, input ready);
    modport sink (input valid, input key_on, input duration, input unsupported,
                  input last, output ready);
endinterface

/* src/mkse_front.sv */
`timescale 1ns / 1ps

module mkse_front (
    mkse_char_if.sink        i_char,
    input  mkse_pkg::t_q_status i_q_stat,
    output logic             o_push,
    output mkse_pkg::t_desc  o_desc
);
    import mkse_pkg::*;

    logic w_out_of_range;

    // A request is taken whenever the queue has room.
    assign i_char.ready = !i_q_stat.full;
    assign o_push       = i_char.valid && !i_q_stat.full;

    // Classify the character: out-of-range codes carry no symbols.
    assign w_out_of_range = (i_char.char_code < CODE_FIRST) || (i_char.char_code > CODE_LAST);

    always_comb begin
        if (w_out_of_range) begin
            o_desc = '{len: '0, dash: '0, space: 1'b0, unsup: 1'b1};
        end else begin
            o_desc = mkse_lookup(i_char.char_code);
        end
    end
endmodule

/* src/mkse_queue.sv */
`timescale 1ns / 1ps

module mkse_queue #(
    parameter int DEPTH = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  mkse_pkg::t_desc        i_desc,
    input  logic                   i_pop,
    output mkse_pkg::t_desc        o_desc,
    output mkse_pkg::t_q_status    o_stat
);
    import mkse_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_desc          r_mem [DEPTH];
    logic [PW-1:0]  r_wptr, n_wptr;
    logic [PW-1:0]  r_rptr, n_rptr;
    logic [CW-1:0]  r_count, n_count;
    logic           w_push, w_pop;

    // Guard the strobes against a full or empty queue.
    assign w_push = i_push && (r_count != CW'(DEPTH));
    assign w_pop  = i_pop && (r_count != '0);

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_desc       = r_mem[r_rptr];

    // Pointer and fill count updates with wrap at the queue depth.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : PW'(r_wptr + 1'b1);
        end
        if (w_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : PW'(r_rptr + 1'b1);
        end
        if (w_push && !w_pop) begin
            n_count = CW'(r_count + 1'b1);
        end else if (w_pop && !w_push) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_desc;
        end
    end
endmodule

/* src/mkse_back.sv */
`timescale 1ns / 1ps

module mkse_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mkse_pkg::DOT_W-1:0]    i_dot_len,
    input  mkse_pkg::t_desc               i_desc,
    input  mkse_pkg::t_q_status           i_q_stat,
    output logic                          o_pop,
    mkse_seg_if.source                    o_seg
);
    import mkse_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MARK,
        ST_SEP,
        ST_GAP
    } t_state;

    t_state               r_state, n_state;
    t_desc                r_desc, n_desc;
    logic [LEN_W-1:0]     r_idx, n_idx;
    logic                 r_valid, n_valid;
    logic                 r_key, n_key;
    logic [DUR_W-1:0]     r_dur, n_dur;
    logic                 r_unsup, n_unsup;
    logic                 r_last, n_last;
    logic                 w_adv;
    logic                 w_emit;
    logic                 w_seg_key;
    logic [UNITS_W-1:0]   w_seg_units;
    logic [DUR_W-1:0]     w_seg_dur;
    logic [LEN_W-1:0]     w_idx_inc;

    // The output register takes a new segment when empty or being drained.
    assign w_adv     = !r_valid || o_seg.ready;
    assign o_pop     = (r_state == ST_IDLE) && !i_q_stat.empty;
    assign w_idx_inc = LEN_W'(r_idx + 1'b1);

    // Key level and length of the segment the current state sends.
    always_comb begin
        w_seg_key   = 1'b0;
        w_seg_units = UNITS_GAP;
        case (r_state)
            ST_MARK: begin
                w_seg_key = !r_desc.space;
                if (r_desc.space) begin
                    w_seg_units = UNITS_WORD;
                end else if (r_desc.dash[r_idx]) begin
                    w_seg_units = UNITS_DASH;
                end else begin
                    w_seg_units = UNITS_DOT;
                end
            end
            ST_SEP: begin
                w_seg_units = UNITS_SEP;
            end
            default: begin
                w_seg_units = UNITS_GAP;
            end
        endcase
    end

    assign w_seg_dur = DUR_W'(w_seg_units) * DUR_W'(i_dot_len);
    assign w_emit    = w_adv && (r_state != ST_IDLE);

    // Sequencer: fetches a character, then sends one segment per cycle while the output stage has room.
    always_comb begin
        n_state = r_state;
        n_desc  = r_desc;
        n_idx   = r_idx;
        n_valid = r_valid && !o_seg.ready;
        n_key   = r_key;
        n_dur   = r_dur;
        n_unsup = r_unsup;
        n_last  = r_last;
        if (w_emit) begin
            n_valid = 1'b1;
            n_key   = w_seg_key;
            n_dur   = w_seg_dur;
            n_unsup = r_desc.unsup;
            n_last  = (r_state == ST_GAP);
        end
        case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_desc  = i_desc;
                    n_idx   = '0;
                    n_state = (i_desc.len == '0) ? ST_GAP : ST_MARK;
                end
            end
            ST_MARK: begin
                if (w_adv) begin
                    n_state = ST_SEP;
                end
            end
            ST_SEP: begin
                if (w_adv) begin
                    n_idx   = w_idx_inc;
                    n_state = (w_idx_inc == r_desc.len) ? ST_GAP : ST_MARK;
                end
            end
            ST_GAP: begin
                if (w_adv) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_desc  <= n_desc;
        r_idx   <= n_idx;
        r_key   <= n_key;
        r_dur   <= n_dur;
        r_unsup <= n_unsup;
        r_last  <= n_last;
    end

    assign o_seg.valid       = r_valid;
    assign o_seg.key_on      = r_key;
    assign o_seg.duration    = r_dur;
    assign o_seg.unsupported = r_unsup;
    assign o_seg.last        = r_last;
endmodule

/* src/morse_keying_segment_encoder.sv */
// The first segment of a character passes the queue, the back fetch state and the output register.
// For each character the back sequencer fetches from the queue, then sends a mark and a
// separating space per symbol and a closing gap, one segment per cycle while the output has room.
// Requests are taken while the queue between front and back has room.
// Reset is synchronous, active low; it empties the queue and output and sets dot length 75.
`timescale 1ns / 1ps

module morse_keying_segment_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mkse_pkg::DOT_W-1:0]  i_cfg_data,
    mkse_char_if.sink                   i_char,
    mkse_seg_if.source                  o_seg
);
    import mkse_pkg::*;

    logic [DOT_W-1:0] r_dot_len;
    logic             w_push;
    logic             w_pop;
    t_desc            w_front_desc;
    t_desc            w_queue_desc;
    t_q_status        w_q_stat;

    // Dot length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_len <= DOT_LEN_RESET;
        end else if (i_cfg_we) begin
            r_dot_len <= i_cfg_data;
        end
    end

    // Front: accepts and classifies characters.
    mkse_front u_front (
        .i_char   (i_char),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_desc   (w_front_desc)
    );

    // Queue of classified characters.
    mkse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_front_desc),
        .i_pop   (w_pop),
        .o_desc  (w_queue_desc),
        .o_stat  (w_q_stat)
    );

    // Back: sends the key segments.
    mkse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_dot_len (r_dot_len),
        .i_desc    (w_queue_desc),
        .i_q_stat  (w_q_stat),
        .o_pop     (w_pop),
        .o_seg     (o_seg)
    );

`ifndef ASSERT_OFF
    // An out-of-range character yields only the closing gap.
    a_unsup_gap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_seg.valid && o_seg.unsupported |-> o_seg.last && !o_seg.key_on)
        else $error("unsupported segment is not a final gap");

    // A keyed segment is always followed by a separating space.
    a_key_not_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_seg.valid && o_seg.key_on |-> !o_seg.last)
        else $error("keyed segment marked last");

    // The queue never reports full and empty at once.
    a_queue_stat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty))
        else $error("queue status inconsistent");

    // A fetch from the queue never happens while it is empty.
    a_pop_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("pop from empty queue");
`endif
endmodule
